// ===== hdl/tphd_pkg.sv =====
// Shared constants and types for the tape pulse header decoder.
`timescale 1ns / 1ps
`default_nettype none

package tphd_pkg;

  // Pilot and frame geometry
  localparam int unsigned PILOT_MIN = 1000;
  localparam int unsigned RUN_BITS  = 11;
  localparam int unsigned NAME_LEN  = 16;
  localparam int unsigned PAD_LEN   = 171;
  localparam int unsigned SYNC_LEN  = 9;
  localparam int unsigned HDR_LEN   = 5 + NAME_LEN + PAD_LEN;
  localparam int unsigned SYNC_TOP  = 8'h80 + SYNC_LEN;
  localparam int unsigned POS_BITS  = 24;
  localparam int unsigned NAME_AW   = $clog2(NAME_LEN);

  // Field widths
  localparam int unsigned PULSE_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR16  = 16;
  localparam int unsigned PSTART_W = 24;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SHORT_MIN  = 3'd0,
    CFG_SHORT_MAX  = 3'd1,
    CFG_MIDDLE_MIN = 3'd2,
    CFG_MIDDLE_MAX = 3'd3,
    CFG_LONG_MIN   = 3'd4,
    CFG_LONG_MAX   = 3'd5
  } cfg_idx_t;

  // Window reset values
  localparam logic [7:0] RST_SHORT_MIN  = 8'd36;
  localparam logic [7:0] RST_SHORT_MAX  = 8'd54;
  localparam logic [7:0] RST_MIDDLE_MIN = 8'd55;
  localparam logic [7:0] RST_MIDDLE_MAX = 8'd73;
  localparam logic [7:0] RST_LONG_MIN   = 8'd74;
  localparam logic [7:0] RST_LONG_MAX   = 8'd100;

endpackage

`default_nettype wire

// ===== hdl/tape_pulse_header_decoder_top.sv =====
// Tape pulse header decoder: pulse classifier, byte framer, header checker and emitter.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one pulse length per cycle while it is not emitting, and
// tracks pilot search, byte framing and header checksum in registers; the
// sixteen file name bytes live in a 16x8 RAM with registered read. Every pulse
// or rewind transaction that produces no result is taken back to back. When a
// checksum byte matches, the block produces 17 transactions: one header item
// and then the 16 name items, one per cycle from the output register unless the
// output stalls, the name RAM being streamed one address ahead. While those 17
// items are loaded the input is held off; the last item may still wait in the
// output register while new pulses are taken. The name RAM needs no clearing
// pass: each entry is written before a header can finish. Configuration writes
// are taken at any time.

module tape_pulse_header_decoder_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Pulse channel
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tphd_pkg::PULSE_W-1:0]     in_pulse,
  input  wire logic                             in_rewind,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  out_kind,
  output logic      [tphd_pkg::BYTE_W-1:0]      out_file_index,
  output logic      [tphd_pkg::BYTE_W-1:0]      out_file_type,
  output logic      [tphd_pkg::ADDR16-1:0]      out_load_start,
  output logic      [tphd_pkg::ADDR16-1:0]      out_load_end,
  output logic      [tphd_pkg::PSTART_W-1:0]    out_pilot_start,
  output logic      [tphd_pkg::BYTE_W-1:0]      out_name_byte,
  output logic                                  out_last,
  // Configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [7:0]                       cfg_data
);

  import tphd_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_LONG,
    PH_MIDDLE,
    PH_FIRST,
    PH_SECOND
  } phase_t;

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [7:0]          BC_HDR_END = 8'(SYNC_LEN + HDR_LEN);

  // Window registers
  logic [7:0] short_min_r, short_max_r, middle_min_r, middle_max_r;
  logic [7:0] long_min_r, long_max_r;

  // Decoder state
  phase_t                 phase_r, phase_nxt;
  logic [RUN_BITS-1:0]    short_run_r, short_run_nxt;
  logic [POS_BITS-1:0]    position_r, position_nxt;
  logic [POS_BITS-1:0]    run_start_r, run_start_nxt;
  logic [7:0]             pair_first_r, pair_first_nxt;
  logic [3:0]             bit_count_r, bit_count_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic                   parity_r, parity_nxt;
  logic [7:0]             byte_count_r, byte_count_nxt;
  logic [7:0]             xor_sum_r, xor_sum_nxt;
  logic [39:0]            header_r, header_nxt;
  logic [7:0]             file_count_r, file_count_nxt;

  // Emitter state
  logic                   busy_r, busy_nxt;
  logic                   hdr_pend_r, hdr_pend_nxt;
  logic [NAME_AW-1:0]     name_ptr_r, name_ptr_nxt;
  logic [7:0]             fidx_r, fidx_nxt;

  // Output register
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [7:0]             out_fidx_r, out_fidx_nxt;
  logic [7:0]             out_type_r, out_type_nxt;
  logic [15:0]            out_start_r, out_start_nxt;
  logic [15:0]            out_end_r, out_end_nxt;
  logic [PSTART_W-1:0]    out_pstart_r, out_pstart_nxt;
  logic [7:0]             out_name_r, out_name_nxt;
  logic                   out_last_r, out_last_nxt;

  // Name RAM ports
  logic                   ram_we;
  logic [NAME_AW-1:0]     ram_wa;
  logic [7:0]             ram_rd;

  // Datapath helpers
  logic                   in_acc, load;
  logic                   p_short, p_middle, p_long, pf_middle, bit_v, par_n;
  logic [RUN_BITS-1:0]    run_inc;
  logic [2:0]             hdr_idx;
  logic [7:0]             sync_exp;

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load      = busy_r && (!out_valid_r || out_ready);

  // Classify the pulse and the held first pulse of a pair
  assign p_short   = (in_pulse >= short_min_r) && (in_pulse <= short_max_r);
  assign p_middle  = (in_pulse >= middle_min_r) && (in_pulse <= middle_max_r);
  assign p_long    = (in_pulse >= long_min_r) && (in_pulse <= long_max_r);
  assign pf_middle = (pair_first_r >= middle_min_r) && (pair_first_r <= middle_max_r);
  assign bit_v     = pf_middle && p_short;
  assign par_n     = parity_r ^ bit_v;

  assign run_inc   = (short_run_r == RUN_MAX) ? RUN_MAX : short_run_r + 1'b1;
  assign hdr_idx   = 3'(byte_count_r - 8'(SYNC_LEN));
  assign ram_wa    = NAME_AW'(byte_count_r - 8'(SYNC_LEN + 5));
  assign sync_exp  = 8'(SYNC_TOP) - byte_count_r;

  tphd_ram #(
    .WIDTH (8),
    .DEPTH (NAME_LEN)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (shift_r),
    .rd_addr (name_ptr_nxt),
    .rd_data (ram_rd)
  );

  // Decode one pulse transaction and drive the emitter
  always_comb begin
    phase_nxt      = phase_r;
    short_run_nxt  = short_run_r;
    position_nxt   = position_r;
    run_start_nxt  = run_start_r;
    pair_first_nxt = pair_first_r;
    bit_count_nxt  = bit_count_r;
    shift_nxt      = shift_r;
    parity_nxt     = parity_r;
    byte_count_nxt = byte_count_r;
    xor_sum_nxt    = xor_sum_r;
    header_nxt     = header_r;
    file_count_nxt = file_count_r;
    busy_nxt       = busy_r;
    hdr_pend_nxt   = hdr_pend_r;
    name_ptr_nxt   = name_ptr_r;
    fidx_nxt       = fidx_r;
    ram_we         = 1'b0;

    if (in_acc) begin
      if (in_rewind) begin
        // Clear position, search state and file count
        position_nxt   = '0;
        file_count_nxt = '0;
        phase_nxt      = PH_SEARCH;
        short_run_nxt  = '0;
        run_start_nxt  = '0;
        pair_first_nxt = '0;
        bit_count_nxt  = '0;
        shift_nxt      = '0;
        parity_nxt     = 1'b1;
        byte_count_nxt = '0;
        xor_sum_nxt    = '0;
        header_nxt     = '0;
      end else begin
        if (position_r != POS_MAX) begin
          position_nxt = position_r + 1'b1;
        end
        case (phase_r)
          PH_SEARCH: begin
            if (p_short) begin
              if (short_run_r == '0) begin
                run_start_nxt = position_r;
              end
              short_run_nxt = run_inc;
              if (run_inc >= RUN_BITS'(PILOT_MIN)) begin
                phase_nxt = PH_SKIP;
              end
            end else begin
              short_run_nxt = '0;
            end
          end
          PH_SKIP: begin
            // First non-short pulse is the long marker of the first sync byte
            if (!p_short) begin
              byte_count_nxt = '0;
              xor_sum_nxt    = '0;
              bit_count_nxt  = '0;
              shift_nxt      = '0;
              parity_nxt     = 1'b1;
              if (p_long) begin
                phase_nxt = PH_MIDDLE;
              end else begin
                phase_nxt     = PH_SEARCH;
                short_run_nxt = '0;
              end
            end
          end
          PH_LONG: begin
            if (p_long) begin
              phase_nxt = PH_MIDDLE;
            end else begin
              phase_nxt     = PH_SEARCH;
              short_run_nxt = '0;
            end
          end
          PH_MIDDLE: begin
            if (p_middle) begin
              phase_nxt = PH_FIRST;
            end else begin
              phase_nxt     = PH_SEARCH;
              short_run_nxt = '0;
            end
          end
          PH_FIRST: begin
            pair_first_nxt = in_pulse;
            phase_nxt      = PH_SECOND;
          end
          PH_SECOND: begin
            parity_nxt = par_n;
            if (bit_count_r < 4'd8) begin
              // Shift in data bits LSB first
              shift_nxt     = {bit_v, shift_r[7:1]};
              bit_count_nxt = bit_count_r + 1'b1;
              phase_nxt     = PH_FIRST;
            end else if (par_n) begin
              phase_nxt     = PH_SEARCH;
              short_run_nxt = '0;
            end else if (byte_count_r < 8'(SYNC_LEN)) begin
              // Sync byte check
              if (shift_r != sync_exp) begin
                phase_nxt     = PH_SEARCH;
                short_run_nxt = '0;
              end else begin
                byte_count_nxt = byte_count_r + 1'b1;
                phase_nxt      = PH_LONG;
                bit_count_nxt  = '0;
                shift_nxt      = '0;
                parity_nxt     = 1'b1;
              end
            end else if (byte_count_r < BC_HDR_END) begin
              // Header body: fields, then name bytes into RAM, then pad
              xor_sum_nxt = xor_sum_r ^ shift_r;
              if (byte_count_r < 8'(SYNC_LEN + 5)) begin
                case (hdr_idx)
                  3'd0:    header_nxt[7:0]   = shift_r;
                  3'd1:    header_nxt[15:8]  = shift_r;
                  3'd2:    header_nxt[23:16] = shift_r;
                  3'd3:    header_nxt[31:24] = shift_r;
                  default: header_nxt[39:32] = shift_r;
                endcase
              end else if (byte_count_r < 8'(SYNC_LEN + 5 + NAME_LEN)) begin
                ram_we = 1'b1;
              end
              byte_count_nxt = byte_count_r + 1'b1;
              phase_nxt      = PH_LONG;
              bit_count_nxt  = '0;
              shift_nxt      = '0;
              parity_nxt     = 1'b1;
            end else begin
              // Checksum byte: start emission on match
              phase_nxt     = PH_SEARCH;
              short_run_nxt = '0;
              if (shift_r == xor_sum_r) begin
                busy_nxt     = 1'b1;
                hdr_pend_nxt = 1'b1;
                fidx_nxt     = file_count_r;
                if (file_count_r != 8'hFF) begin
                  file_count_nxt = file_count_r + 1'b1;
                end
              end
            end
          end
          default: begin
            phase_nxt     = PH_SEARCH;
            short_run_nxt = '0;
          end
        endcase
      end
    end

    // Emitter: header item, then name items streamed from RAM
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_fidx_nxt   = out_fidx_r;
    out_type_nxt   = out_type_r;
    out_start_nxt  = out_start_r;
    out_end_nxt    = out_end_r;
    out_pstart_nxt = out_pstart_r;
    out_name_nxt   = out_name_r;
    out_last_nxt   = out_last_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_fidx_nxt   = fidx_r;
      out_type_nxt   = header_r[7:0];
      out_start_nxt  = header_r[23:8];
      out_end_nxt    = header_r[39:24];
      out_pstart_nxt = PSTART_W'(run_start_r);
      if (hdr_pend_r) begin
        out_kind_nxt = 1'b0;
        out_name_nxt = '0;
        out_last_nxt = 1'b0;
        hdr_pend_nxt = 1'b0;
      end else begin
        out_kind_nxt = 1'b1;
        out_name_nxt = ram_rd;
        out_last_nxt = (name_ptr_r == NAME_AW'(NAME_LEN - 1));
        name_ptr_nxt = name_ptr_r + 1'b1;
        if (name_ptr_r == NAME_AW'(NAME_LEN - 1)) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r  <= RST_SHORT_MIN;
      short_max_r  <= RST_SHORT_MAX;
      middle_min_r <= RST_MIDDLE_MIN;
      middle_max_r <= RST_MIDDLE_MAX;
      long_min_r   <= RST_LONG_MIN;
      long_max_r   <= RST_LONG_MAX;
      phase_r      <= PH_SEARCH;
      short_run_r  <= '0;
      position_r   <= '0;
      run_start_r  <= '0;
      pair_first_r <= '0;
      bit_count_r  <= '0;
      shift_r      <= '0;
      parity_r     <= 1'b1;
      byte_count_r <= '0;
      xor_sum_r    <= '0;
      header_r     <= '0;
      file_count_r <= '0;
      busy_r       <= 1'b0;
      hdr_pend_r   <= 1'b0;
      name_ptr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT_MIN:  short_min_r  <= cfg_data;
          CFG_SHORT_MAX:  short_max_r  <= cfg_data;
          CFG_MIDDLE_MIN: middle_min_r <= cfg_data;
          CFG_MIDDLE_MAX: middle_max_r <= cfg_data;
          CFG_LONG_MIN:   long_min_r   <= cfg_data;
          CFG_LONG_MAX:   long_max_r   <= cfg_data;
          default: ;
        endcase
      end
      phase_r      <= phase_nxt;
      short_run_r  <= short_run_nxt;
      position_r   <= position_nxt;
      run_start_r  <= run_start_nxt;
      pair_first_r <= pair_first_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_r      <= shift_nxt;
      parity_r     <= parity_nxt;
      byte_count_r <= byte_count_nxt;
      xor_sum_r    <= xor_sum_nxt;
      header_r     <= header_nxt;
      file_count_r <= file_count_nxt;
      busy_r       <= busy_nxt;
      hdr_pend_r   <= hdr_pend_nxt;
      name_ptr_r   <= name_ptr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    // Payload registers
    fidx_r       <= fidx_nxt;
    out_kind_r   <= out_kind_nxt;
    out_fidx_r   <= out_fidx_nxt;
    out_type_r   <= out_type_nxt;
    out_start_r  <= out_start_nxt;
    out_end_r    <= out_end_nxt;
    out_pstart_r <= out_pstart_nxt;
    out_name_r   <= out_name_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_file_index  = out_fidx_r;
  assign out_file_type   = out_type_r;
  assign out_load_start  = out_start_r;
  assign out_load_end    = out_end_r;
  assign out_pilot_start = out_pstart_r;
  assign out_name_byte   = out_name_r;
  assign out_last        = out_last_r;

  // Emission starts only after a checksum byte in the last frame slot
  a_start_on_checksum: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(phase_r == PH_SECOND) && ($past(byte_count_r) == BC_HDR_END))
    else $error("emission started outside the checksum byte");

  // Header item is pending only during an emission
  a_hdr_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pend_r |-> busy_r)
    else $error("header pending while emitter idle");

  // Loading the final name item ends the emission
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    load && !hdr_pend_r && (name_ptr_r == NAME_AW'(NAME_LEN - 1)) |=> !busy_r && out_last_r)
    else $error("emission did not end on the last name byte");

  // Header fields and name store stay frozen while items are emitted
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && $past(busy_r) |-> $stable(header_r) && $stable(run_start_r) && !ram_we)
    else $error("decoder state changed during emission");

endmodule

`default_nettype wire

// ===== hdl/tphd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tphd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the tape pulse header decoder: directed pulses, framed tape streams.
`timescale 1ns / 1ps

module tb_top;
  import tphd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RUN_MAX     = (1 << RUN_BITS) - 1;
  localparam int unsigned FIELD_BYTES = HDR_LEN - NAME_LEN - PAD_LEN;
  localparam int unsigned FRAME_BYTES = SYNC_LEN + HDR_LEN + 1;

  typedef enum int {CLS_SHORT, CLS_MIDDLE, CLS_LONG} pulse_class_t;
  typedef enum int {FAULT_NONE, FAULT_MARKER, FAULT_PARITY, FAULT_SYNC, FAULT_SUM} frame_fault_t;
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} stall_mode_t;
  typedef enum logic [2:0] {
    ST_SEARCH, ST_SKIP, ST_LONG, ST_MIDDLE, ST_FIRST, ST_SECOND
  } tape_state_t;

  typedef struct {
    logic [PULSE_W-1:0] pulse;
    logic               rewind;
  } tape_item_t;

  typedef struct {
    logic                kind;
    logic [BYTE_W-1:0]   file_index;
    logic [BYTE_W-1:0]   file_type;
    logic [ADDR16-1:0]   load_start;
    logic [ADDR16-1:0]   load_end;
    logic [PSTART_W-1:0] pilot_start;
    logic [BYTE_W-1:0]   name_byte;
    logic                last;
  } tape_record_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [PULSE_W-1:0]  in_pulse = '0;
  logic                in_rewind = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_kind;
  logic [BYTE_W-1:0]   out_file_index;
  logic [BYTE_W-1:0]   out_file_type;
  logic [ADDR16-1:0]   out_load_start;
  logic [ADDR16-1:0]   out_load_end;
  logic [PSTART_W-1:0] out_pilot_start;
  logic [BYTE_W-1:0]   out_name_byte;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [7:0]          cfg_data = '0;

  tape_pulse_header_decoder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pulse        (in_pulse),
    .in_rewind       (in_rewind),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_file_index  (out_file_index),
    .out_file_type   (out_file_type),
    .out_load_start  (out_load_start),
    .out_load_end    (out_load_end),
    .out_pilot_start (out_pilot_start),
    .out_name_byte   (out_name_byte),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Pending stimulus and expected results
  tape_item_t   pulse_backlog[$];
  tape_record_t expected_records[$];

  // Window copy of the classifier
  logic [7:0] win_lo [3];
  logic [7:0] win_hi [3];

  // Decoder state mirror
  tape_state_t         st;
  int unsigned         short_run;
  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] run_start;
  logic [7:0]          pair_first;
  int unsigned         bit_cnt;
  logic [7:0]          shift_byte;
  logic                parity_acc;
  int unsigned         byte_cnt;
  logic [7:0]          xsum;
  logic [7:0]          hdr_bytes [FIELD_BYTES];
  logic [7:0]          names [NAME_LEN];
  logic [7:0]          files_found;

  int unsigned mismatches = 0;
  int unsigned pulses_taken = 0;
  int unsigned records_checked = 0;
  int unsigned headers_checked = 0;
  int unsigned cycle_count = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned mode_left = 0;
  stall_mode_t rx_mode = RX_OPEN;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic in_class(pulse_class_t c, logic [7:0] p);
    return p >= win_lo[c] && p <= win_hi[c];
  endfunction

  function automatic void clear_decoder();
    st = ST_SEARCH;
    short_run = 0;
    run_start = '0;
    pair_first = '0;
    bit_cnt = 0;
    shift_byte = '0;
    parity_acc = 1'b1;
    byte_cnt = 0;
    xsum = '0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    foreach (names[i]) names[i] = '0;
  endfunction

  function automatic void drop_frame();
    st = ST_SEARCH;
    short_run = 0;
  endfunction

  function automatic void start_byte();
    st = ST_LONG;
    bit_cnt = 0;
    shift_byte = '0;
    parity_acc = 1'b1;
  endfunction

  // Advance the decoder mirror by one accepted pulse transaction
  function automatic void decode_pulse(logic [7:0] p, logic rewind);
    logic [POS_BITS-1:0] here;
    logic                bit_val;
    int unsigned         slot;
    tape_record_t        rec;
    if (rewind) begin
      pos = '0;
      files_found = '0;
      clear_decoder();
      return;
    end
    here = pos;
    if (pos != '1) pos++;
    case (st)
      ST_SEARCH: begin
        if (in_class(CLS_SHORT, p)) begin
          if (short_run == 0) run_start = here;
          if (short_run < RUN_MAX) short_run++;
          if (short_run >= PILOT_MIN) st = ST_SKIP;
        end else begin
          short_run = 0;
        end
      end
      ST_SKIP: begin
        // first non-short pulse after the pilot is the first long marker
        if (!in_class(CLS_SHORT, p)) begin
          byte_cnt = 0;
          xsum = '0;
          start_byte();
          if (in_class(CLS_LONG, p)) st = ST_MIDDLE;
          else drop_frame();
        end
      end
      ST_LONG: begin
        if (in_class(CLS_LONG, p)) st = ST_MIDDLE;
        else drop_frame();
      end
      ST_MIDDLE: begin
        if (in_class(CLS_MIDDLE, p)) st = ST_FIRST;
        else drop_frame();
      end
      ST_FIRST: begin
        pair_first = p;
        st = ST_SECOND;
      end
      ST_SECOND: begin
        bit_val = in_class(CLS_MIDDLE, pair_first) && in_class(CLS_SHORT, p);
        parity_acc ^= bit_val;
        if (bit_cnt < 8) begin
          shift_byte = {bit_val, shift_byte[7:1]};
          bit_cnt++;
          st = ST_FIRST;
        end else if (parity_acc) begin
          drop_frame();
        end else if (byte_cnt < SYNC_LEN) begin
          if (shift_byte != 8'(SYNC_TOP - byte_cnt)) begin
            drop_frame();
          end else begin
            byte_cnt++;
            start_byte();
          end
        end else if (byte_cnt < SYNC_LEN + HDR_LEN) begin
          slot = byte_cnt - SYNC_LEN;
          xsum ^= shift_byte;
          if (slot < FIELD_BYTES) hdr_bytes[slot] = shift_byte;
          else if (slot < FIELD_BYTES + NAME_LEN) names[slot - FIELD_BYTES] = shift_byte;
          byte_cnt++;
          start_byte();
        end else if (shift_byte != xsum) begin
          drop_frame();
        end else begin
          // checksum good: header record, then the name records
          rec.kind = 1'b0;
          rec.file_index = files_found;
          rec.file_type = hdr_bytes[0];
          rec.load_start = {hdr_bytes[2], hdr_bytes[1]};
          rec.load_end = {hdr_bytes[4], hdr_bytes[3]};
          rec.pilot_start = run_start[PSTART_W-1:0];
          rec.name_byte = '0;
          rec.last = 1'b0;
          expected_records.push_back(rec);
          rec.kind = 1'b1;
          for (int i = 0; i < NAME_LEN; i++) begin
            rec.name_byte = names[i];
            rec.last = (i == NAME_LEN - 1);
            expected_records.push_back(rec);
          end
          if (files_found != 8'hFF) files_found++;
          drop_frame();
        end
      end
      default: drop_frame();
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Stimulus builders
  function automatic void push_item(logic [7:0] p, logic rw);
    tape_item_t it;
    it.pulse = p;
    it.rewind = rw;
    pulse_backlog.push_back(it);
  endfunction

  function automatic logic [7:0] pick(pulse_class_t c);
    if (win_lo[c] > win_hi[c]) return 8'($urandom_range(255, 0));
    return 8'($urandom_range(win_hi[c], win_lo[c]));
  endfunction

  function automatic void send_bit(logic b);
    if (b) begin
      push_item(pick(CLS_MIDDLE), 1'b0);
      push_item(pick(CLS_SHORT), 1'b0);
    end else begin
      case ($urandom_range(4, 0))
        0: begin
          push_item(pick(CLS_SHORT), 1'b0);
          push_item(pick(CLS_SHORT), 1'b0);
        end
        1: begin
          push_item(pick(CLS_SHORT), 1'b0);
          push_item(pick(CLS_MIDDLE), 1'b0);
        end
        2: begin
          push_item(pick(CLS_LONG), 1'b0);
          push_item(pick(CLS_SHORT), 1'b0);
        end
        3: begin
          push_item(pick(CLS_MIDDLE), 1'b0);
          push_item(pick(CLS_MIDDLE), 1'b0);
        end
        default: begin
          push_item(pick(CLS_MIDDLE), 1'b0);
          push_item(pick(CLS_LONG), 1'b0);
        end
      endcase
    end
  endfunction

  function automatic void send_byte(logic [7:0] value, frame_fault_t fault);
    int unsigned which;
    which = $urandom_range(1, 0);
    if (fault == FAULT_MARKER && which == 0) push_item(pick(CLS_MIDDLE), 1'b0);
    else push_item(pick(CLS_LONG), 1'b0);
    if (fault == FAULT_MARKER && which == 1) push_item(pick(CLS_LONG), 1'b0);
    else push_item(pick(CLS_MIDDLE), 1'b0);
    for (int i = 0; i < 8; i++) send_bit(value[i]);
    send_bit(~(^value) ^ (fault == FAULT_PARITY));
  endfunction

  // Build one tape frame: pilot, sync bytes, header, checksum, trailing shorts
  function automatic void send_frame(int unsigned pilot_len, frame_fault_t fault);
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [7:0]  sum;
    int unsigned bad_at;
    sum = '0;
    for (int i = 0; i < SYNC_LEN; i++) frame_bytes[i] = 8'(SYNC_TOP - i);
    for (int i = 0; i < HDR_LEN; i++) begin
      frame_bytes[SYNC_LEN + i] = 8'($urandom);
      sum ^= frame_bytes[SYNC_LEN + i];
    end
    frame_bytes[FRAME_BYTES - 1] = sum;
    case (fault)
      FAULT_MARKER, FAULT_PARITY: begin
        bad_at = $urandom_range(1, 0) ? 0 : $urandom_range(FRAME_BYTES - 1, 0);
      end
      FAULT_SYNC: begin
        bad_at = $urandom_range(SYNC_LEN - 1, 0);
        frame_bytes[bad_at] ^= 8'(1 << $urandom_range(7, 0));
      end
      FAULT_SUM: begin
        bad_at = FRAME_BYTES - 1;
        frame_bytes[bad_at] ^= 8'(1 << $urandom_range(7, 0));
      end
      default: bad_at = FRAME_BYTES;
    endcase
    repeat (pilot_len) push_item(pick(CLS_SHORT), 1'b0);
    for (int i = 0; i < FRAME_BYTES && i <= bad_at; i++) begin
      send_byte(frame_bytes[i], (i == bad_at) ? fault : FAULT_NONE);
    end
    repeat ($urandom_range(30, 8)) push_item(pick(CLS_SHORT), 1'b0);
  endfunction

  // Random pulses, biased toward window edges, with occasional rewinds
  function automatic void send_noise(int unsigned count);
    pulse_class_t c;
    int unsigned  r;
    repeat (count) begin
      c = pulse_class_t'($urandom_range(2, 0));
      r = $urandom_range(19, 0);
      if (r == 0) push_item(8'($urandom), 1'b1);
      else if (r < 10) push_item(8'($urandom), 1'b0);
      else if (r < 12) push_item(8'(win_lo[c] - 1), 1'b0);
      else if (r < 15) push_item(win_lo[c], 1'b0);
      else if (r < 18) push_item(win_hi[c], 1'b0);
      else push_item(8'(win_hi[c] + 1), 1'b0);
    end
  endfunction

  // Wait until every pulse is taken and every result is back, then settle
  task automatic drain();
    while (pulse_backlog.size() != 0 || in_valid || expected_records.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SHORT_MIN:  win_lo[CLS_SHORT] = value;
      CFG_SHORT_MAX:  win_hi[CLS_SHORT] = value;
      CFG_MIDDLE_MIN: win_lo[CLS_MIDDLE] = value;
      CFG_MIDDLE_MAX: win_hi[CLS_MIDDLE] = value;
      CFG_LONG_MIN:   win_lo[CLS_LONG] = value;
      CFG_LONG_MAX:   win_hi[CLS_LONG] = value;
      default: ;
    endcase
  endtask

  task automatic write_windows(logic [7:0] s_lo, logic [7:0] s_hi, logic [7:0] m_lo,
                               logic [7:0] m_hi, logic [7:0] l_lo, logic [7:0] l_hi);
    write_reg(CFG_SHORT_MIN, s_lo);
    write_reg(CFG_SHORT_MAX, s_hi);
    write_reg(CFG_MIDDLE_MIN, m_lo);
    write_reg(CFG_MIDDLE_MAX, m_hi);
    write_reg(CFG_LONG_MIN, l_lo);
    write_reg(CFG_LONG_MAX, l_hi);
  endtask

  // Driver: offer pulses in bursts, predict on each accepted transaction
  always @(posedge clk) begin
    tape_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_pulse(in_pulse, in_rewind);
        pulses_taken++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pulse_backlog.size() > 0) begin
          nxt = pulse_backlog.pop_front();
          in_valid <= 1'b1;
          in_pulse <= nxt.pulse;
          in_rewind <= nxt.rewind;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(400, 100)
                                                     : $urandom_range(20, 1);
            gap_left = $urandom_range(6, 0);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a changing pattern, hold off long after early headers
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready && !out_kind && holds_done < 2) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = stall_mode_t'($urandom_range(3, 0));
        mode_left = $urandom_range(256, 32);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(3, 0) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    tape_record_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $error("result with nothing expected: kind %0d name_byte 0x%0h", out_kind, out_name_byte);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("file_index", want.file_index, out_file_index);
        check_field("file_type", want.file_type, out_file_type);
        check_field("load_start", want.load_start, out_load_start);
        check_field("load_end", want.load_end, out_load_end);
        check_field("pilot_start", want.pilot_start, out_pilot_start);
        check_field("name_byte", want.name_byte, out_name_byte);
        check_field("last", want.last, out_last);
        records_checked++;
        if (!want.kind) headers_checked++;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tape_pulse_header_decoder_top regression: fail");
    $finish;
  end

  // Sequence the phases
  initial begin
    int unsigned s_lo, s_hi, m_lo, m_hi, l_lo, l_hi;
    win_lo[CLS_SHORT] = RST_SHORT_MIN;
    win_hi[CLS_SHORT] = RST_SHORT_MAX;
    win_lo[CLS_MIDDLE] = RST_MIDDLE_MIN;
    win_hi[CLS_MIDDLE] = RST_MIDDLE_MAX;
    win_lo[CLS_LONG] = RST_LONG_MIN;
    win_hi[CLS_LONG] = RST_LONG_MAX;
    pos = '0;
    files_found = '0;
    clear_decoder();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, window edges at reset values, rewinds
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(8'd35, 1'b0);
    push_item(8'd36, 1'b0);
    push_item(8'd54, 1'b0);
    push_item(8'd55, 1'b0);
    push_item(8'd73, 1'b0);
    push_item(8'd74, 1'b0);
    push_item(8'd100, 1'b0);
    push_item(8'd101, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'h55, 1'b0);
    push_item(8'hFF, 1'b1);
    push_item(8'd40, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'h00, 1'b1);
    push_item(8'd36, 1'b0);
    push_item(8'd54, 1'b0);
    drain();

    // Widest windows: short pilot, minimum pilot, saturating pilot
    write_windows(8'd0, 8'd50, 8'd51, 8'd120, 8'd121, 8'd255);
    send_noise(60);
    send_frame(PILOT_MIN - 1, FAULT_NONE);
    send_frame(PILOT_MIN, FAULT_NONE);
    send_frame(RUN_MAX + 50, FAULT_NONE);
    drain();

    // Reset windows: each frame fault, then rewind and clean frames
    write_windows(RST_SHORT_MIN, RST_SHORT_MAX, RST_MIDDLE_MIN, RST_MIDDLE_MAX,
                  RST_LONG_MIN, RST_LONG_MAX);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_MARKER);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_PARITY);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_SYNC);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_SUM);
    push_item(8'($urandom), 1'b1);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_NONE);
    send_noise(40);
    send_frame(PILOT_MIN + $urandom_range(40, 0), FAULT_NONE);
    drain();

    // Overlapping windows
    write_windows(8'd40, 8'd80, 8'd60, 8'd100, 8'd90, 8'd200);
    send_noise(150);
    send_frame(PILOT_MIN + 20, FAULT_NONE);
    drain();

    // Crossed windows match nothing
    write_windows(8'd200, 8'd10, 8'd255, 8'd0, 8'd128, 8'd127);
    send_noise(80);
    drain();

    // Random disjoint windows
    s_lo = $urandom_range(20, 0);
    s_hi = s_lo + $urandom_range(30, 5);
    m_lo = s_hi + 1 + $urandom_range(5, 0);
    m_hi = m_lo + $urandom_range(30, 5);
    l_lo = m_hi + 1 + $urandom_range(5, 0);
    l_hi = l_lo + $urandom_range(60, 5);
    write_windows(8'(s_lo), 8'(s_hi), 8'(m_lo), 8'(m_hi), 8'(l_lo), 8'(l_hi));
    send_frame(PILOT_MIN + $urandom_range(200, 0), FAULT_NONE);
    send_frame(PILOT_MIN + $urandom_range(200, 0), FAULT_SUM);
    send_noise(30);
    send_frame(PILOT_MIN + $urandom_range(200, 0), FAULT_NONE);
    drain();

    repeat (SETTLE) @(posedge clk);
    if (expected_records.size() != 0) begin
      $error("%0d expected results never arrived", expected_records.size());
      mismatches++;
    end
    $display("Summary: %0d pulse transactions accepted, %0d result transactions checked, %0d headers",
             pulses_taken, records_checked, headers_checked);
    $display("Summary: five window settings, frame faults of every kind, rewinds and long stalls");
    if (mismatches == 0) begin
      $display("tape_pulse_header_decoder_top regression: pass");
    end else begin
      $display("tape_pulse_header_decoder_top regression: fail");
    end
    $finish;
  end

endmodule
